// ----- rtl/core/rgsf_pkg.sv -----
`default_nettype none
package rgsf_pkg;

  localparam int unsigned MaxFillPackets = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LimW = 16 + $clog2(MaxFillPackets + 2);
  localparam logic [7:0] SilUlaw = 8'hff;
  localparam logic [7:0] SilAlaw = 8'hd5;

  typedef enum logic [0:0] {
    CfgPacketOctets = 1'b0,
    CfgAlawMode     = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StFill,
    StPass
  } state_e;

  typedef struct packed {
    logic [31:0] rtp_time;
    logic [15:0] length_octets;
    logic [31:0] ext_sequence;
    logic        batch_start;
  } in_t;

  typedef struct packed {
    logic        is_filler;
    logic [31:0] out_time;
    logic [15:0] out_octets;
    logic [7:0]  fill_value;
    logic [31:0] out_sequence;
    logic        gap_too_long;
    logic        last_of_run;
  } out_t;

endpackage
`default_nettype wire

// ----- rtl/core/rgsf_if.sv -----
`default_nettype none
interface rgsf_in_if;
  import rgsf_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rgsf_out_if;
  import rgsf_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rgsf_sub_unit.sv -----
`default_nettype none
module rgsf_sub_unit (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] diff_o,
  output logic        borrow_o
);
  import rgsf_pkg::*;

  logic [32:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[31:0];
  assign borrow_o = full[32];

endmodule
`default_nettype wire

// ----- rtl/core/rtp_gap_silence_filler.sv -----
`default_nettype none
// RTP gap silence filler for G.711 streams.
// Packet descriptors enter on in_i and results leave on out_o; both channels
// move one beat when valid and ready are high at a rising clock edge.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Index 0 sets the packet size, index 1 selects A-law.
// One input beat produces zero or more silence beats followed by the passed
// packet, which carries last_of_run. The block takes one packet at a time;
// in_i.ready is high only between packets. A packet moves from StCheck
// through StFill, which sends 1 to 17 filler beats when the gap is
// filled, to StPass; in_i.ready rises again as its last result is
// registered. A single subtractor is shared by the gap computation and
// by each filler step, which sets one filler per cycle while the receiver
// does not stall. Results sit in an output register; when the receiver
// stalls the sequencer holds its place and nothing is dropped.
// Reset restores packet size 160, mu-law, and an expected timestamp of zero.
module rtp_gap_silence_filler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  rgsf_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [rgsf_pkg::CfgDataW-1:0]  cfg_data_i,
  rgsf_in_if.sink                        in_i,
  rgsf_out_if.source                     out_o
);
  import rgsf_pkg::*;

  state_e      state_q, state_d;
  in_t         item_q, item_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] left_q, left_d;
  logic        too_long_q, too_long_d;
  logic [15:0] pkt_q;
  logic        alaw_q;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  logic [31:0]     sub_a, sub_b, sub_diff;
  logic            sub_borrow;
  logic [LimW-1:0] limit;
  logic [15:0]     step;
  logic            out_free;

  rgsf_sub_unit u_sub (
    .a_i      (sub_a),
    .b_i      (sub_b),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  assign limit    = {{(LimW - 16){1'b0}}, pkt_q} * LimW'(MaxFillPackets + 1);
  assign out_free = !out_valid_q || out_o.ready;
  assign step     = sub_borrow ? left_q[15:0] : pkt_q;

  always_comb begin
    if (state_q == StCheck) begin
      sub_a = item_q.rtp_time;
      sub_b = exp_q;
    end else begin
      sub_a = left_q;
      sub_b = {16'b0, pkt_q};
    end
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    exp_d       = exp_q;
    left_d      = left_q;
    too_long_d  = too_long_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;
    case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          item_d  = in_i.data;
          exp_d   = in_i.data.batch_start ? in_i.data.rtp_time : exp_q;
          state_d = StCheck;
        end
      end
      StCheck: begin
        left_d = sub_diff;
        if (sub_diff == 32'd0) begin
          too_long_d = 1'b0;
          state_d    = StPass;
        end else if (pkt_q == 16'd0 || sub_diff >= {{(32 - LimW){1'b0}}, limit}) begin
          too_long_d = 1'b1;
          state_d    = StPass;
        end else begin
          too_long_d = 1'b0;
          state_d    = StFill;
        end
      end
      StFill: begin
        if (left_q == 32'd0) begin
          state_d = StPass;
        end else if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.is_filler    = 1'b1;
          out_d.out_time     = exp_q;
          out_d.out_octets   = step;
          out_d.fill_value   = alaw_q ? SilAlaw : SilUlaw;
          out_d.out_sequence = item_q.ext_sequence;
          out_d.gap_too_long = 1'b0;
          out_d.last_of_run  = 1'b0;
          left_d             = sub_borrow ? 32'd0 : sub_diff;
          exp_d              = exp_q + {16'b0, step};
        end
      end
      StPass: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.is_filler    = 1'b0;
          out_d.out_time     = item_q.rtp_time;
          out_d.out_octets   = item_q.length_octets;
          out_d.fill_value   = 8'd0;
          out_d.out_sequence = item_q.ext_sequence;
          out_d.gap_too_long = too_long_q;
          out_d.last_of_run  = 1'b1;
          exp_d              = item_q.rtp_time + {16'b0, item_q.length_octets};
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      exp_q       <= 32'd0;
      pkt_q       <= 16'd160;
      alaw_q      <= 1'b0;
      out_valid_q <= 1'b0;
      too_long_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      exp_q       <= exp_d;
      out_valid_q <= out_valid_d;
      too_long_q  <= too_long_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPacketOctets: pkt_q  <= cfg_data_i;
          CfgAlawMode:     alaw_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    left_q <= left_d;
    out_q  <= out_d;
  end

  assign in_i.ready  = (state_q == StIdle);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while a packet is in progress");

  a_left_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFill && $past(state_q) == StFill) |-> left_q <= $past(left_q))
    else $error("remaining gap grew during fill");

  a_filler_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.is_filler) |->
      (out_o.data.out_octets != 16'd0 && out_o.data.out_octets <= pkt_q &&
       !out_o.data.last_of_run && !out_o.data.gap_too_long))
    else $error("malformed filler beat");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.data)))
    else $error("result beat changed while stalled");

endmodule
`default_nettype wire

// ----- dv/rtp_gap_silence_filler_test.sv -----
`timescale 1ns / 1ps

module rtp_gap_silence_filler_test;
  import rgsf_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  rgsf_in_if  in_bus ();
  rgsf_out_if out_bus ();

  rtp_gap_silence_filler u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // Local copy of the filler state and configuration.
  logic [31:0] next_ts;
  logic [15:0] pkt_octets;
  logic        alaw_sel;
  out_t        expected_beats[$];
  int unsigned mismatch_count;
  bit          idle_en;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t: %s got %h want %h", $time, what, got, want);
  endtask

  function automatic int unsigned pick_idle();
    int unsigned r;
    if (!idle_en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic void predict_packet(input in_t pkt);
    logic [31:0] gap;
    logic [31:0] whole;
    logic [31:0] left;
    logic [31:0] p32;
    logic [31:0] step;
    int unsigned count;
    int unsigned i;
    logic        too_long;
    out_t        beat;
    too_long = 1'b0;
    p32 = {16'b0, pkt_octets};
    if (pkt.batch_start) begin
      next_ts = pkt.rtp_time;
    end
    if (pkt.rtp_time != next_ts) begin
      gap = pkt.rtp_time - next_ts;
      if (p32 == 32'd0) begin
        too_long = 1'b1;
      end else begin
        whole = gap / p32;
        if (whole <= MaxFillPackets) begin
          count = whole + (((gap % p32) != 32'd0) ? 1 : 0);
          left = gap;
          for (i = 0; i < count; i++) begin
            step = (p32 > left) ? left : p32;
            beat.is_filler    = 1'b1;
            beat.out_time     = next_ts;
            beat.out_octets   = step[15:0];
            beat.fill_value   = alaw_sel ? SilAlaw : SilUlaw;
            beat.out_sequence = pkt.ext_sequence;
            beat.gap_too_long = 1'b0;
            beat.last_of_run  = 1'b0;
            expected_beats.push_back(beat);
            left    = left - step;
            next_ts = next_ts + step;
          end
        end else begin
          too_long = 1'b1;
        end
      end
    end
    beat.is_filler    = 1'b0;
    beat.out_time     = pkt.rtp_time;
    beat.out_octets   = pkt.length_octets;
    beat.fill_value   = 8'h00;
    beat.out_sequence = pkt.ext_sequence;
    beat.gap_too_long = too_long;
    beat.last_of_run  = 1'b1;
    expected_beats.push_back(beat);
    next_ts = pkt.rtp_time + {16'b0, pkt.length_octets};
  endfunction

  function automatic in_t make_packet(input logic [31:0] t, input logic [15:0] len,
                                      input logic [31:0] seq, input logic start);
    in_t pkt;
    pkt.rtp_time      = t;
    pkt.length_octets = len;
    pkt.ext_sequence  = seq;
    pkt.batch_start   = start;
    return pkt;
  endfunction

  // Mostly well-formed continuations of the stream, the rest is noise.
  function automatic in_t next_stream_packet();
    logic [31:0] p32;
    logic [31:0] gap;
    logic [31:0] t;
    logic [15:0] len;
    logic        start;
    int unsigned r;
    p32 = {16'b0, pkt_octets};
    r = $urandom_range(0, 99);
    if (r < 60) begin
      len = pkt_octets;
    end else if (r < 85) begin
      len = 16'($urandom_range(0, 400));
    end else begin
      len = 16'($urandom);
    end
    r = $urandom_range(0, 99);
    if (r < 20) begin
      return make_packet($urandom, 16'($urandom), $urandom, 1'($urandom_range(0, 1)));
    end
    start = ($urandom_range(0, 9) == 0);
    r = $urandom_range(0, 9);
    if (r < 4) begin
      gap = 32'd0;
    end else if (r < 8) begin
      gap = (p32 == 32'd0) ? $urandom_range(1, 50) : $urandom_range(1, 17 * p32 - 1);
    end else if (r == 8) begin
      gap = 16 * p32 + ((p32 == 32'd0) ? 32'd1 : $urandom_range(0, p32 - 1));
    end else if ($urandom_range(0, 1) == 0) begin
      gap = 17 * p32 + $urandom_range(0, 3);
    end else begin
      gap = 32'd0 - $urandom_range(1, 100);
    end
    t = start ? $urandom : next_ts + gap;
    return make_packet(t, len, $urandom, start);
  endfunction

  task automatic send_packet(input in_t pkt);
    int unsigned idle;
    idle = pick_idle();
    @(negedge clk_i);
    if (idle != 0) begin
      in_bus.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= pkt;
    do @(posedge clk_i); while (!in_bus.ready);
    predict_packet(pkt);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgPacketOctets: begin
        pkt_octets = value[15:0];
      end
      CfgAlawMode: begin
        alaw_sel = value[0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic [15:0] octets, input logic alaw);
    drain_results();
    write_cfg(CfgPacketOctets, octets);
    write_cfg(CfgAlawMode, {{(CfgDataW - 1){1'b0}}, alaw});
  endtask

  task automatic test_reset_expectation();
    send_packet(make_packet(32'd480, 16'd160, 32'd1000, 1'b0));
    send_packet(make_packet(next_ts, 16'd160, 32'd1001, 1'b0));
    send_packet(make_packet(next_ts + 32'd50, 16'd160, 32'd1002, 1'b0));
  endtask

  task automatic test_fill_limit();
    send_packet(make_packet(32'd1000, 16'd160, 32'd2000, 1'b1));
    send_packet(make_packet(next_ts + 32'd2560, 16'd160, 32'd2001, 1'b0));
    send_packet(make_packet(next_ts + 32'd2567, 16'd160, 32'd2002, 1'b0));
    send_packet(make_packet(next_ts + 32'd2720, 16'd160, 32'd2003, 1'b0));
    send_packet(make_packet(next_ts - 32'd1, 16'd160, 32'd2004, 1'b0));
    send_packet(make_packet(next_ts, 16'd0, 32'd2005, 1'b0));
    send_packet(make_packet(next_ts, 16'd160, 32'd2006, 1'b0));
  endtask

  task automatic test_field_extremes();
    send_packet(make_packet(32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b1));
    send_packet(make_packet(next_ts, 16'h0000, 32'h0000_0000, 1'b0));
    send_packet(make_packet(32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1));
    send_packet(make_packet(32'hffff_ff00, 16'h0200, 32'h8000_0000, 1'b1));
    send_packet(make_packet(next_ts + 32'd100, 16'd160, 32'h7fff_ffff, 1'b0));
  endtask

  task automatic test_alaw_fill();
    set_config(16'd160, 1'b1);
    send_packet(make_packet(32'd5000, 16'd160, 32'd3000, 1'b1));
    send_packet(make_packet(next_ts + 32'd481, 16'd160, 32'd3001, 1'b0));
  endtask

  task automatic test_packet_size_extremes();
    set_config(16'd0, 1'b0);
    send_packet(make_packet(32'd7000, 16'd160, 32'd4000, 1'b1));
    send_packet(make_packet(next_ts + 32'd1, 16'd160, 32'd4001, 1'b0));
    send_packet(make_packet(next_ts, 16'd160, 32'd4002, 1'b0));
    set_config(16'd1, 1'b1);
    send_packet(make_packet(next_ts + 32'd16, 16'd1, 32'd4003, 1'b0));
    send_packet(make_packet(next_ts + 32'd17, 16'd1, 32'd4004, 1'b0));
    set_config(16'hffff, 1'b0);
    send_packet(make_packet(next_ts + 32'd16 * 32'hffff + 32'd9, 16'hffff, 32'd4005, 1'b0));
    send_packet(make_packet(next_ts + 32'd17 * 32'hffff, 16'hffff, 32'd4006, 1'b0));
  endtask

  task automatic test_random_traffic();
    logic [15:0] phase_octets[6];
    logic        phase_alaw[6];
    int unsigned ph;
    int unsigned n;
    phase_octets = '{16'd160, 16'd1, 16'hffff, 16'd80, 16'd0, 16'd0};
    phase_alaw   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_octets[5] = 16'($urandom_range(1, 65535));
    phase_alaw[5]   = 1'($urandom_range(0, 1));
    for (ph = 0; ph < 6; ph++) begin
      set_config(phase_octets[ph], phase_alaw[ph]);
      idle_en = ((ph % 3) != 2);
      for (n = 0; n < 31; n++) begin
        send_packet(next_stream_packet());
      end
    end
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin
      int unsigned stall;
      stall = pick_idle();
      if (stall != 0) begin
        @(negedge clk_i);
        out_bus.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_beats
    out_t got;
    out_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got = out_bus.data;
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, out_time", got.out_time, 32'd0);
      end else begin
        want = expected_beats[0];
        expected_beats.delete(0);
        if (got.is_filler != want.is_filler)
          report_mismatch("is_filler", 32'(got.is_filler), 32'(want.is_filler));
        if (got.out_time != want.out_time)
          report_mismatch("out_time", got.out_time, want.out_time);
        if (got.out_octets != want.out_octets)
          report_mismatch("out_octets", 32'(got.out_octets), 32'(want.out_octets));
        if (got.fill_value != want.fill_value)
          report_mismatch("fill_value", 32'(got.fill_value), 32'(want.fill_value));
        if (got.out_sequence != want.out_sequence)
          report_mismatch("out_sequence", got.out_sequence, want.out_sequence);
        if (got.gap_too_long != want.gap_too_long)
          report_mismatch("gap_too_long", 32'(got.gap_too_long), 32'(want.gap_too_long));
        if (got.last_of_run != want.last_of_run)
          report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgPacketOctets;
    cfg_data_i     = '0;
    in_bus.valid   = 1'b0;
    in_bus.data    = '0;
    next_ts        = 32'd0;
    pkt_octets     = 16'd160;
    alaw_sel       = 1'b0;
    mismatch_count = 0;
    idle_en        = 1'b1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_reset_expectation();
    test_fill_limit();
    test_field_extremes();
    test_alaw_fill();
    test_packet_size_extremes();
    test_random_traffic();
    drain_results();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rgsf_pkg.sv
rtl/core/rgsf_if.sv
rtl/core/rgsf_sub_unit.sv
rtl/core/rtp_gap_silence_filler.sv
dv/rtp_gap_silence_filler_test.sv
